[src/swm_pkg.sv]
// Shared types and constants for the sliding window median filter.
`default_nettype none

package swm_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int WS_W   = 7;

  localparam logic [WS_W-1:0] WS_RESET = 7'd3;

  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic capture;
    logic rd_old;
    logic remove;
    logic insert;
    logic sel;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic full;
    logic emit;
    logic out_busy;
  } swm_status_t;

endpackage

`default_nettype wire

[src/swm_regs.sv]
// APB-style configuration register block holding the window size.
`default_nettype none

module swm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [swm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [swm_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [swm_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output logic      [swm_pkg::WS_W-1:0]     window_size,
  output logic                              restart
);
  import swm_pkg::*;

  logic [WS_W-1:0] window_size_r;
  logic [WS_W-1:0] window_size_nxt;
  logic            wr_en;
  logic            sel_ws;

  assign cfg_pready = 1'b1;
  assign sel_ws     = (cfg_paddr[2] == REG_WINDOW_SIZE);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign restart    = wr_en & sel_ws;

  always_comb begin
    window_size_nxt = window_size_r;
    if (restart) begin
      window_size_nxt = cfg_pwdata[WS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_RESET;
    end else begin
      window_size_r <= window_size_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_ws) begin
      cfg_prdata = CFG_DW'(window_size_r);
    end
  end

  assign window_size = window_size_r;

endmodule

`default_nettype wire

[src/swm_ctrl.sv]
// Controller state machine sequencing read, remove, insert and median select.
`default_nettype none

module swm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t         cmd
);
  import swm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_REMOVE = 6'b000100,
    ST_INSERT = 6'b001000,
    ST_SEL    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = status.full ? ST_READ : ST_INSERT;
        end
      end
      ST_READ: begin
        cmd.rd_old = 1'b1;
        state_nxt  = ST_REMOVE;
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = status.emit ? ST_SEL : ST_IDLE;
      end
      ST_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register frees up
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[src/swm_dp.sv]
// Datapath: arrival ring memory, sorted cell row, median select and output register.
`default_nettype none

module swm_dp #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [swm_pkg::WS_W-1:0]       window_size,
  input  wire logic                           restart,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic signed [SAMPLE_WIDTH-1:0]      out_median,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  input  wire swm_pkg::swm_cmd_t              cmd,
  output swm_pkg::swm_status_t                status
);
  import swm_pkg::*;

  localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int EW   = (CW > WS_W) ? CW : WS_W;
  localparam int NGRP = (WINDOW_MAX + 7) / 8;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PW   = GW + 3;

  logic signed [SAMPLE_WIDTH-1:0] ring_mem [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_r   [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_nxt [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] grp_r    [NGRP];
  logic signed [SAMPLE_WIDTH-1:0] grp_nxt  [NGRP];
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic signed [SAMPLE_WIDTH-1:0] old_r;
  logic signed [SAMPLE_WIDTH-1:0] median_r;
  logic signed [SAMPLE_WIDTH-1:0] median_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [CW-1:0]                  fill_r;
  logic [CW-1:0]                  fill_nxt;
  logic [IW-1:0]                  ptr_r;
  logic [IW-1:0]                  ptr_nxt;
  logic                           full_mode_r;
  logic                           emit_r;
  logic [EW-1:0]                  ws_ext;
  logic [CW-1:0]                  win;
  logic [CW-1:0]                  ins_cnt;
  logic [IW-1:0]                  ring_waddr;
  logic [IW-1:0]                  med_idx;
  logic [PW-1:0]                  med_pad;
  logic [WINDOW_MAX-1:0]          gt;
  logic                           full_now;

  // clamp the programmed size into 1..WINDOW_MAX
  always_comb begin
    ws_ext = EW'(window_size);
    if (ws_ext == '0) begin
      win = CW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      win = CW'(WINDOW_MAX);
    end else begin
      win = CW'(ws_ext);
    end
  end

  assign full_now = (fill_r >= win);
  assign med_idx  = IW'((win - CW'(1)) >> 1);
  assign med_pad  = PW'(med_idx);

  assign status.full     = full_now;
  assign status.emit     = emit_r;
  assign status.out_busy = out_valid_r & ~out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r    <= in_sample;
      full_mode_r <= full_now;
      emit_r      <= full_now | ((fill_r + CW'(1)) == win);
    end
  end

  // arrival ring: one write port, registered read
  assign ring_waddr = full_mode_r ? ptr_r : fill_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_old) begin
      old_r <= ring_mem[ptr_r];
    end
    if (cmd.insert) begin
      ring_mem[ring_waddr] <= sample_r;
    end
  end

  // fill count and oldest pointer
  always_comb begin
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    if (restart) begin
      fill_nxt = '0;
      ptr_nxt  = '0;
    end else if (cmd.insert) begin
      if (full_mode_r) begin
        if ((CW'(ptr_r) + CW'(1)) == win) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_r + IW'(1);
        end
      end else begin
        fill_nxt = fill_r + CW'(1);
        ptr_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ptr_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  // sorted cell row: each cell looks only at its neighbors
  assign ins_cnt = full_mode_r ? (win - CW'(1)) : fill_r;

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      gt[i] = (i < int'(ins_cnt)) ? (cell_r[i] > sample_r) : 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    if (cmd.remove) begin
      // every cell from the first copy of the evicted value onward moves down
      for (int i = 0; i < WINDOW_MAX - 1; i++) begin
        if ((i < int'(win) - 1) && (cell_r[i] >= old_r)) begin
          cell_nxt[i] = cell_r[i + 1];
        end
      end
    end else if (cmd.insert) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (gt[i]) begin
          cell_nxt[i] = sample_r;
        end
      end
      for (int i = 1; i < WINDOW_MAX; i++) begin
        if (gt[i] && gt[i - 1]) begin
          cell_nxt[i] = cell_r[i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  // median select, first level: one entry per group of eight cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if ((g * 8 + j < WINDOW_MAX) && (med_pad[2:0] == 3'(j))) begin
          grp_nxt[g] = cell_r[(g * 8 + j) % WINDOW_MAX];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // second level and output register
  always_comb begin
    median_nxt    = median_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      median_nxt    = '0;
      for (int g = 0; g < NGRP; g++) begin
        if (med_pad[PW-1:3] == GW'(g)) begin
          median_nxt = grp_r[g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_median = median_r;
  assign out_valid  = out_valid_r;

endmodule

`default_nettype wire

[src/sliding_window_median.sv]
// Sliding window median filter: lower median over the last window_size samples.
// Sequence: a filling sample with no result is captured and inserted; the sample that fills
//   the window adds median select and emit; a sample into a full window first does a ring
//   read and a remove pass, then the insert pass over the sorted cell row, the two-level
//   median select and emit, which holds while output is busy; input is taken only in idle.
// Reset: window_size returns to 3, fill count, ring pointer and output valid clear; no sweep.
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_median,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [swm_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [swm_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic      [swm_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import swm_pkg::*;

  logic [WS_W-1:0] window_size;
  logic            restart;
  swm_cmd_t        cmd;
  swm_status_t     status;

  swm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .window_size (window_size),
    .restart     (restart)
  );

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .window_size (window_size),
    .restart     (restart),
    .in_sample   (in_sample),
    .out_median  (out_median),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire
